// ===== sv/rvd_pkg.sv =====
// rvd_pkg: shared types, codes and decode tables for the rv64im instruction decoder
package rvd_pkg;

  localparam int unsigned InDataBits  = 104;
  localparam int unsigned OutDataBits = 144;

  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_MULDIV = 7'h01;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [5:0] F6_LOGIC  = 6'h00;
  localparam logic [5:0] F6_ARITH  = 6'h10;

  localparam logic [2:0] LEN_SHORT = 3'd1;
  localparam logic [2:0] LEN_COMP  = 3'd2;
  localparam logic [2:0] LEN_FULL  = 3'd4;

  localparam logic [11:0] SYS_ECALL  = 12'h000;
  localparam logic [11:0] SYS_EBREAK = 12'h001;

  typedef enum logic [3:0] {
    FORM_NONE, FORM_R, FORM_I, FORM_SHIFT, FORM_MEM, FORM_S, FORM_B, FORM_U,
    FORM_J, FORM_CSR_REG, FORM_CSR_IMM
  } form_e;

  typedef enum logic [5:0] {
    MN_NONE,
    MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU, MN_XORI, MN_SRLI, MN_SRAI, MN_ORI, MN_ANDI,
    MN_ADD, MN_SUB, MN_MUL, MN_SLL, MN_MULH, MN_SLT, MN_MULHSU, MN_SLTU, MN_MULHU,
    MN_XOR, MN_DIV, MN_SRL, MN_SRA, MN_DIVU, MN_OR, MN_REM, MN_AND, MN_REMU,
    MN_LB, MN_LH, MN_LW, MN_LD, MN_LBU, MN_LHU, MN_LWU,
    MN_SB, MN_SH, MN_SW, MN_SD,
    MN_BEQ, MN_BNE, MN_BLT, MN_BGE, MN_BLTU, MN_BGEU,
    MN_JAL, MN_JALR, MN_LUI, MN_AUIPC, MN_ECALL, MN_EBREAK,
    MN_CSRRW, MN_CSRRS, MN_CSRRC, MN_CSRRWI, MN_CSRRSI, MN_CSRRCI
  } mnem_e;

  typedef struct packed {
    logic        is_bad;
    logic [2:0]  len;
    mnem_e       mnem;
    form_e       form;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [32:0] imm;
    logic [11:0] csr;
    logic        has_target;
    logic [63:0] pc;
  } s1_t;

  typedef struct packed {
    logic        is_bad;
    logic [2:0]  len;
    mnem_e       mnem;
    form_e       form;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [32:0] imm;
    logic [11:0] csr;
    logic [31:0] sum_lo;
    logic        carry;
    logic [31:0] pc_hi;
    logic [31:0] imm_hi;
  } s2_t;

  typedef struct packed {
    logic        is_bad;
    logic [2:0]  len;
    mnem_e       mnem;
    form_e       form;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [32:0] imm;
    logic [11:0] csr;
    logic [63:0] target;
  } res_t;

  function automatic mnem_e opimm_mnem(input logic [2:0] f3);
    mnem_e m;
    case (f3)
      3'd0:    m = MN_ADDI;
      3'd1:    m = MN_SLLI;
      3'd2:    m = MN_SLTI;
      3'd3:    m = MN_SLTIU;
      3'd4:    m = MN_XORI;
      3'd5:    m = MN_SRLI;
      3'd6:    m = MN_ORI;
      default: m = MN_ANDI;
    endcase
    return m;
  endfunction

  function automatic mnem_e op_base_mnem(input logic [2:0] f3);
    mnem_e m;
    case (f3)
      3'd0:    m = MN_ADD;
      3'd1:    m = MN_SLL;
      3'd2:    m = MN_SLT;
      3'd3:    m = MN_SLTU;
      3'd4:    m = MN_XOR;
      3'd5:    m = MN_SRL;
      3'd6:    m = MN_OR;
      default: m = MN_AND;
    endcase
    return m;
  endfunction

  function automatic mnem_e op_m_mnem(input logic [2:0] f3);
    mnem_e m;
    case (f3)
      3'd0:    m = MN_MUL;
      3'd1:    m = MN_MULH;
      3'd2:    m = MN_MULHSU;
      3'd3:    m = MN_MULHU;
      3'd4:    m = MN_DIV;
      3'd5:    m = MN_DIVU;
      3'd6:    m = MN_REM;
      default: m = MN_REMU;
    endcase
    return m;
  endfunction

  function automatic mnem_e br_mnem(input logic [2:0] f3);
    mnem_e m;
    case (f3)
      3'd0:    m = MN_BEQ;
      3'd1:    m = MN_BNE;
      3'd4:    m = MN_BLT;
      3'd5:    m = MN_BGE;
      3'd6:    m = MN_BLTU;
      3'd7:    m = MN_BGEU;
      default: m = MN_NONE;
    endcase
    return m;
  endfunction

endpackage

// ===== sv/rv64im_instruction_decoder.sv =====
// rv64im_instruction_decoder: top level of the three-stage rv64im decoder
//
// Slave stream takes one instruction beat: the 32-bit little-endian word, the
// count of valid bytes and the pc. Master stream gives one result beat for
// each input beat, in order: bad flag, length, mnemonic index, operand form,
// register fields, immediate, csr number and branch or jal target.
// Pipeline: classify, operand masking with low target add, high target add.
// Each accepted input beat passes through the three pipeline registers to its
// result; throughput is one beat per cycle while m_axis_tready stays high.
// Each stage holds its beat while the next one is full and stalled, so a
// stalled receiver backs up the pipe stage by stage and s_axis_tready falls
// only once all three stages are full. Nothing is lost or repeated.
// Reset clears every stage valid bit; the block takes input right after.
module rv64im_instruction_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // insn_word, bytes_available, pc, zero pad
  input  logic [rvd_pkg::InDataBits-1:0]    s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // is_bad, insn_length, mnemonic_index, operand_form, dest_reg, src1_reg,
  // src2_reg, immediate, csr_number, target_address, zero pad
  output logic [rvd_pkg::OutDataBits-1:0]   m_axis_tdata
);

  logic          s1_valid, s1_ready, s2_valid, s2_ready;
  rvd_pkg::s1_t  s1_data;
  rvd_pkg::s2_t  s2_data;
  rvd_pkg::res_t res;

  rvd_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .word_i  (s_axis_tdata[31:0]),
    .avail_i (s_axis_tdata[34:32]),
    .pc_i    (s_axis_tdata[98:35]),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  rvd_operands u_operands (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  rvd_target u_target (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  assign m_axis_tdata = {6'd0, res.target, res.csr, res.imm, res.rs2, res.rs1, res.rd,
                         res.form, res.mnem, res.len, res.is_bad};

  a_empty_out_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_bad_fields_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.is_bad |->
      res.mnem == rvd_pkg::MN_NONE && res.form == rvd_pkg::FORM_NONE &&
      res.imm == '0 && res.target == '0)
    else $error("bad beat carries decoded fields");

  a_good_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !res.is_bad |->
      res.len == rvd_pkg::LEN_FULL && res.mnem != rvd_pkg::MN_NONE)
    else $error("decoded beat with wrong length or no mnemonic");

  a_target_only_bj: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.form != rvd_pkg::FORM_B && res.form != rvd_pkg::FORM_J |->
      res.target == '0)
    else $error("target set outside branch and jal");

endmodule

// ===== sv/rvd_classify.sv =====
// rvd_classify: first stage, opcode classification and raw immediate extraction
module rvd_classify (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [31:0]      word_i,
  input  logic [2:0]       avail_i,
  input  logic [63:0]      pc_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rvd_pkg::s1_t     data_o
);

  logic         valid_q;
  rvd_pkg::s1_t data_q, data_d;

  logic [6:0] opc, f7;
  logic [2:0] f3;
  logic [5:0] f6;
  rvd_pkg::mnem_e mnem;
  rvd_pkg::form_e form;
  logic [32:0] imm;
  logic        has_target;

  assign opc = word_i[6:0];
  assign f3  = word_i[14:12];
  assign f7  = word_i[31:25];
  assign f6  = word_i[31:26];

  always_comb begin
    mnem       = rvd_pkg::MN_NONE;
    form       = rvd_pkg::FORM_NONE;
    imm        = '0;
    has_target = 1'b0;
    case (opc)
      rvd_pkg::OPC_OP_IMM: begin
        if (f3 inside {3'd1, 3'd5}) begin
          form = rvd_pkg::FORM_SHIFT;
          imm  = {27'd0, word_i[25:20]};
          if (f3 == 3'd1) begin
            mnem = (f6 == rvd_pkg::F6_LOGIC) ? rvd_pkg::MN_SLLI : rvd_pkg::MN_NONE;
          end else if (f6 == rvd_pkg::F6_LOGIC) begin
            mnem = rvd_pkg::MN_SRLI;
          end else if (f6 == rvd_pkg::F6_ARITH) begin
            mnem = rvd_pkg::MN_SRAI;
          end
        end else begin
          form = rvd_pkg::FORM_I;
          mnem = rvd_pkg::opimm_mnem(f3);
          imm  = {{21{word_i[31]}}, word_i[31:20]};
        end
      end
      rvd_pkg::OPC_OP: begin
        form = rvd_pkg::FORM_R;
        if (f7 == rvd_pkg::F7_BASE) begin
          mnem = rvd_pkg::op_base_mnem(f3);
        end else if (f7 == rvd_pkg::F7_MULDIV) begin
          mnem = rvd_pkg::op_m_mnem(f3);
        end else if (f7 == rvd_pkg::F7_ALT) begin
          if (f3 == 3'd0) begin
            mnem = rvd_pkg::MN_SUB;
          end else if (f3 == 3'd5) begin
            mnem = rvd_pkg::MN_SRA;
          end
        end
      end
      rvd_pkg::OPC_LOAD: begin
        form = rvd_pkg::FORM_MEM;
        if (f3 != 3'd7) begin
          mnem = rvd_pkg::mnem_e'(6'(rvd_pkg::MN_LB) + 6'(f3));
        end
        imm = {{21{word_i[31]}}, word_i[31:20]};
      end
      rvd_pkg::OPC_STORE: begin
        form = rvd_pkg::FORM_S;
        if (!f3[2]) begin
          mnem = rvd_pkg::mnem_e'(6'(rvd_pkg::MN_SB) + 6'(f3));
        end
        imm = {{21{word_i[31]}}, word_i[31:25], word_i[11:7]};
      end
      rvd_pkg::OPC_BRANCH: begin
        form       = rvd_pkg::FORM_B;
        mnem       = rvd_pkg::br_mnem(f3);
        imm        = {{20{word_i[31]}}, word_i[31], word_i[7], word_i[30:25],
                      word_i[11:8], 1'b0};
        has_target = 1'b1;
      end
      rvd_pkg::OPC_JAL: begin
        form       = rvd_pkg::FORM_J;
        mnem       = rvd_pkg::MN_JAL;
        imm        = {{12{word_i[31]}}, word_i[31], word_i[19:12], word_i[20],
                      word_i[30:21], 1'b0};
        has_target = 1'b1;
      end
      rvd_pkg::OPC_JALR: begin
        form = rvd_pkg::FORM_MEM;
        if (f3 == 3'd0) begin
          mnem = rvd_pkg::MN_JALR;
        end
        imm = {{21{word_i[31]}}, word_i[31:20]};
      end
      rvd_pkg::OPC_LUI, rvd_pkg::OPC_AUIPC: begin
        form = rvd_pkg::FORM_U;
        mnem = (opc == rvd_pkg::OPC_LUI) ? rvd_pkg::MN_LUI : rvd_pkg::MN_AUIPC;
        imm  = {1'b0, word_i[31:12], 12'd0};
      end
      rvd_pkg::OPC_SYSTEM: begin
        if (f3 == 3'd0) begin
          if (word_i[11:7] == 5'd0 && word_i[19:15] == 5'd0) begin
            if (word_i[31:20] == rvd_pkg::SYS_ECALL) begin
              mnem = rvd_pkg::MN_ECALL;
            end else if (word_i[31:20] == rvd_pkg::SYS_EBREAK) begin
              mnem = rvd_pkg::MN_EBREAK;
            end
          end
        end else if (!f3[2]) begin
          form = rvd_pkg::FORM_CSR_REG;
          mnem = rvd_pkg::mnem_e'(6'(rvd_pkg::MN_CSRRW) + 6'(f3) - 6'd1);
        end else if (f3 != 3'd4) begin
          form = rvd_pkg::FORM_CSR_IMM;
          mnem = rvd_pkg::mnem_e'(6'(rvd_pkg::MN_CSRRWI) + 6'(f3) - 6'd5);
        end
      end
      default: begin
        mnem = rvd_pkg::MN_NONE;
      end
    endcase
  end

  always_comb begin
    data_d            = '0;
    data_d.mnem       = mnem;
    data_d.form       = form;
    data_d.rd         = word_i[11:7];
    data_d.rs1        = word_i[19:15];
    data_d.rs2        = word_i[24:20];
    data_d.imm        = imm;
    data_d.csr        = word_i[31:20];
    data_d.has_target = has_target;
    data_d.pc         = pc_i;
    if (avail_i < 3'd4) begin
      data_d.is_bad = 1'b1;
      data_d.len    = rvd_pkg::LEN_SHORT;
    end else if (word_i[1:0] != 2'b11) begin
      data_d.is_bad = 1'b1;
      data_d.len    = rvd_pkg::LEN_COMP;
    end else begin
      data_d.is_bad = (mnem == rvd_pkg::MN_NONE);
      data_d.len    = rvd_pkg::LEN_FULL;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/rvd_operands.sv =====
// rvd_operands: second stage, per-form field masking and low half of the target add
module rvd_operands (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  rvd_pkg::s1_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output rvd_pkg::s2_t data_o
);

  logic         valid_q;
  rvd_pkg::s2_t data_q, data_d;
  logic         use_rd, use_rs1, use_rs2, use_csr, use_target;
  logic [63:0]  pc_m;
  logic [32:0]  imm_m;
  logic [32:0]  sum_lo;

  always_comb begin
    use_rd  = data_i.form inside {rvd_pkg::FORM_R, rvd_pkg::FORM_I, rvd_pkg::FORM_SHIFT,
                                  rvd_pkg::FORM_MEM, rvd_pkg::FORM_U, rvd_pkg::FORM_J,
                                  rvd_pkg::FORM_CSR_REG, rvd_pkg::FORM_CSR_IMM};
    use_rs1 = data_i.form inside {rvd_pkg::FORM_R, rvd_pkg::FORM_I, rvd_pkg::FORM_SHIFT,
                                  rvd_pkg::FORM_MEM, rvd_pkg::FORM_S, rvd_pkg::FORM_B,
                                  rvd_pkg::FORM_CSR_REG, rvd_pkg::FORM_CSR_IMM};
    use_rs2 = data_i.form inside {rvd_pkg::FORM_R, rvd_pkg::FORM_S, rvd_pkg::FORM_B};
    use_csr = data_i.form inside {rvd_pkg::FORM_CSR_REG, rvd_pkg::FORM_CSR_IMM};
    use_target = data_i.has_target && !data_i.is_bad;
    pc_m    = use_target ? data_i.pc : '0;
    imm_m   = use_target ? data_i.imm : '0;
    sum_lo  = {1'b0, pc_m[31:0]} + {1'b0, imm_m[31:0]};

    data_d        = '0;
    data_d.is_bad = data_i.is_bad;
    data_d.len    = data_i.len;
    if (!data_i.is_bad) begin
      data_d.mnem = data_i.mnem;
      data_d.form = data_i.form;
      data_d.rd   = use_rd ? data_i.rd : '0;
      data_d.rs1  = use_rs1 ? data_i.rs1 : '0;
      data_d.rs2  = use_rs2 ? data_i.rs2 : '0;
      data_d.imm  = data_i.imm;
      data_d.csr  = use_csr ? data_i.csr : '0;
    end
    data_d.sum_lo = sum_lo[31:0];
    data_d.carry  = sum_lo[32];
    data_d.pc_hi  = pc_m[63:32];
    data_d.imm_hi = {32{imm_m[32]}};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== sv/rvd_target.sv =====
// rvd_target: third stage, high half of the target add and the output register
module rvd_target (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  rvd_pkg::s2_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output rvd_pkg::res_t data_o
);

  logic          valid_q;
  rvd_pkg::res_t data_q, data_d;
  logic [31:0]   sum_hi;

  always_comb begin
    sum_hi        = data_i.pc_hi + data_i.imm_hi + {31'd0, data_i.carry};
    data_d.is_bad = data_i.is_bad;
    data_d.len    = data_i.len;
    data_d.mnem   = data_i.mnem;
    data_d.form   = data_i.form;
    data_d.rd     = data_i.rd;
    data_d.rs1    = data_i.rs1;
    data_d.rs2    = data_i.rs2;
    data_d.imm    = data_i.imm;
    data_d.csr    = data_i.csr;
    data_d.target = {sum_hi, data_i.sum_lo};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== tb/testbench.sv =====
// testbench: stream-level self-checking test of rv64im_instruction_decoder
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 1000;
  localparam int HoldCycles = 64;

  typedef struct packed {
    logic           is_bad;
    logic [2:0]     len;
    rvd_pkg::mnem_e mnem;
    rvd_pkg::form_e form;
    logic [4:0]     rd;
    logic [4:0]     rs1;
    logic [4:0]     rs2;
    logic [32:0]    imm;
    logic [11:0]    csr;
    logic [63:0]    target;
  } decode_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // insn_word, bytes_available, pc, zero pad
  logic [rvd_pkg::InDataBits-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // is_bad, insn_length, mnemonic_index, operand_form, dest_reg, src1_reg,
  // src2_reg, immediate, csr_number, target_address, zero pad
  logic [rvd_pkg::OutDataBits-1:0] m_axis_tdata;

  decode_t pending_decodes[$];
  bit      mnem_seen[64];
  bit      send_gaps_on;
  bit      recv_gaps_on;
  int      hold_request;
  int      beats_in;
  int      beats_out;
  int      mismatches;
  int      idle_cycles;
  int      input_stall_cycles;

  rv64im_instruction_decoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5ns clk_i = ~clk_i;

  function automatic decode_t decode_insn(input logic [31:0] w, input logic [2:0] avail,
                                          input logic [63:0] pc);
    decode_t     d;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [5:0]  f6;
    logic [32:0] imm_i;
    logic        has_target;
    d = '0;
    d.mnem = rvd_pkg::MN_NONE;
    d.form = rvd_pkg::FORM_NONE;
    d.is_bad = 1'b1;
    f3 = w[14:12];
    f7 = w[31:25];
    f6 = w[31:26];
    imm_i = {{21{w[31]}}, w[31:20]};
    has_target = 1'b0;
    if (avail < 3'd4) begin
      d.len = rvd_pkg::LEN_SHORT;
      return d;
    end
    if (w[1:0] != 2'b11) begin
      d.len = rvd_pkg::LEN_COMP;
      return d;
    end
    d.len = rvd_pkg::LEN_FULL;
    case (w[6:0])
      rvd_pkg::OPC_OP_IMM: begin
        if (f3 == 3'd1 || f3 == 3'd5) begin
          d.form = rvd_pkg::FORM_SHIFT;
          d.imm = {27'd0, w[25:20]};
          if (f6 == rvd_pkg::F6_LOGIC)
            d.mnem = (f3 == 3'd1) ? rvd_pkg::MN_SLLI : rvd_pkg::MN_SRLI;
          else if (f6 == rvd_pkg::F6_ARITH && f3 == 3'd5) d.mnem = rvd_pkg::MN_SRAI;
        end else begin
          d.form = rvd_pkg::FORM_I;
          d.imm = imm_i;
          case (f3)
            3'd0: d.mnem = rvd_pkg::MN_ADDI;
            3'd2: d.mnem = rvd_pkg::MN_SLTI;
            3'd3: d.mnem = rvd_pkg::MN_SLTIU;
            3'd4: d.mnem = rvd_pkg::MN_XORI;
            3'd6: d.mnem = rvd_pkg::MN_ORI;
            default: d.mnem = rvd_pkg::MN_ANDI;
          endcase
        end
      end
      rvd_pkg::OPC_OP: begin
        d.form = rvd_pkg::FORM_R;
        if (f7 == rvd_pkg::F7_BASE) begin
          case (f3)
            3'd0: d.mnem = rvd_pkg::MN_ADD;
            3'd1: d.mnem = rvd_pkg::MN_SLL;
            3'd2: d.mnem = rvd_pkg::MN_SLT;
            3'd3: d.mnem = rvd_pkg::MN_SLTU;
            3'd4: d.mnem = rvd_pkg::MN_XOR;
            3'd5: d.mnem = rvd_pkg::MN_SRL;
            3'd6: d.mnem = rvd_pkg::MN_OR;
            default: d.mnem = rvd_pkg::MN_AND;
          endcase
        end else if (f7 == rvd_pkg::F7_MULDIV) begin
          case (f3)
            3'd0: d.mnem = rvd_pkg::MN_MUL;
            3'd1: d.mnem = rvd_pkg::MN_MULH;
            3'd2: d.mnem = rvd_pkg::MN_MULHSU;
            3'd3: d.mnem = rvd_pkg::MN_MULHU;
            3'd4: d.mnem = rvd_pkg::MN_DIV;
            3'd5: d.mnem = rvd_pkg::MN_DIVU;
            3'd6: d.mnem = rvd_pkg::MN_REM;
            default: d.mnem = rvd_pkg::MN_REMU;
          endcase
        end else if (f7 == rvd_pkg::F7_ALT) begin
          if (f3 == 3'd0) d.mnem = rvd_pkg::MN_SUB;
          else if (f3 == 3'd5) d.mnem = rvd_pkg::MN_SRA;
        end
      end
      rvd_pkg::OPC_LOAD: begin
        d.form = rvd_pkg::FORM_MEM;
        d.imm = imm_i;
        if (f3 != 3'd7) d.mnem = rvd_pkg::mnem_e'(int'(rvd_pkg::MN_LB) + int'(f3));
      end
      rvd_pkg::OPC_STORE: begin
        d.form = rvd_pkg::FORM_S;
        d.imm = {{21{w[31]}}, w[31:25], w[11:7]};
        if (f3 < 3'd4) d.mnem = rvd_pkg::mnem_e'(int'(rvd_pkg::MN_SB) + int'(f3));
      end
      rvd_pkg::OPC_BRANCH: begin
        d.form = rvd_pkg::FORM_B;
        d.imm = {{20{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        has_target = 1'b1;
        case (f3)
          3'd0: d.mnem = rvd_pkg::MN_BEQ;
          3'd1: d.mnem = rvd_pkg::MN_BNE;
          3'd4: d.mnem = rvd_pkg::MN_BLT;
          3'd5: d.mnem = rvd_pkg::MN_BGE;
          3'd6: d.mnem = rvd_pkg::MN_BLTU;
          3'd7: d.mnem = rvd_pkg::MN_BGEU;
          default: d.mnem = rvd_pkg::MN_NONE;
        endcase
      end
      rvd_pkg::OPC_JAL: begin
        d.form = rvd_pkg::FORM_J;
        d.mnem = rvd_pkg::MN_JAL;
        d.imm = {{12{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        has_target = 1'b1;
      end
      rvd_pkg::OPC_JALR: begin
        d.form = rvd_pkg::FORM_MEM;
        d.imm = imm_i;
        if (f3 == 3'd0) d.mnem = rvd_pkg::MN_JALR;
      end
      rvd_pkg::OPC_LUI, rvd_pkg::OPC_AUIPC: begin
        d.form = rvd_pkg::FORM_U;
        d.mnem = (w[6:0] == rvd_pkg::OPC_LUI) ? rvd_pkg::MN_LUI : rvd_pkg::MN_AUIPC;
        d.imm = {1'b0, w[31:12], 12'd0};
      end
      rvd_pkg::OPC_SYSTEM: begin
        if (f3 == 3'd0) begin
          if (w[19:7] == '0 && w[31:20] == rvd_pkg::SYS_ECALL)
            d.mnem = rvd_pkg::MN_ECALL;
          else if (w[19:7] == '0 && w[31:20] == rvd_pkg::SYS_EBREAK)
            d.mnem = rvd_pkg::MN_EBREAK;
        end else if (f3 < 3'd4) begin
          d.form = rvd_pkg::FORM_CSR_REG;
          d.mnem = rvd_pkg::mnem_e'(int'(rvd_pkg::MN_CSRRW) + int'(f3) - 1);
        end else if (f3 > 3'd4) begin
          d.form = rvd_pkg::FORM_CSR_IMM;
          d.mnem = rvd_pkg::mnem_e'(int'(rvd_pkg::MN_CSRRWI) + int'(f3) - 5);
        end
      end
      default: ;
    endcase
    if (d.mnem == rvd_pkg::MN_NONE) begin
      d.form = rvd_pkg::FORM_NONE;
      d.imm = '0;
      return d;
    end
    d.is_bad = 1'b0;
    if (d.form inside {rvd_pkg::FORM_R, rvd_pkg::FORM_I, rvd_pkg::FORM_SHIFT,
                       rvd_pkg::FORM_MEM, rvd_pkg::FORM_U, rvd_pkg::FORM_J,
                       rvd_pkg::FORM_CSR_REG, rvd_pkg::FORM_CSR_IMM})
      d.rd = w[11:7];
    if (d.form inside {rvd_pkg::FORM_R, rvd_pkg::FORM_I, rvd_pkg::FORM_SHIFT,
                       rvd_pkg::FORM_MEM, rvd_pkg::FORM_S, rvd_pkg::FORM_B,
                       rvd_pkg::FORM_CSR_REG, rvd_pkg::FORM_CSR_IMM})
      d.rs1 = w[19:15];
    if (d.form inside {rvd_pkg::FORM_R, rvd_pkg::FORM_S, rvd_pkg::FORM_B})
      d.rs2 = w[24:20];
    if (d.form inside {rvd_pkg::FORM_CSR_REG, rvd_pkg::FORM_CSR_IMM}) d.csr = w[31:20];
    if (has_target) d.target = pc + {{31{d.imm[32]}}, d.imm};
    return d;
  endfunction

  function automatic logic [31:0] insn_fields(input logic [6:0] f7, input logic [4:0] rs2,
                                              input logic [4:0] rs1, input logic [2:0] f3,
                                              input logic [4:0] rd, input logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  // mostly well-formed words with random fields, the rest unknown opcodes and noise
  function automatic logic [31:0] random_insn();
    logic [31:0] w;
    int          pick;
    w = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      case ($urandom_range(0, 9))
        0: w[6:0] = rvd_pkg::OPC_OP_IMM;
        1: w[6:0] = rvd_pkg::OPC_OP;
        2: w[6:0] = rvd_pkg::OPC_LOAD;
        3: w[6:0] = rvd_pkg::OPC_STORE;
        4: w[6:0] = rvd_pkg::OPC_BRANCH;
        5: w[6:0] = rvd_pkg::OPC_JAL;
        6: w[6:0] = rvd_pkg::OPC_JALR;
        7: w[6:0] = rvd_pkg::OPC_LUI;
        8: w[6:0] = rvd_pkg::OPC_AUIPC;
        default: w[6:0] = rvd_pkg::OPC_SYSTEM;
      endcase
      if (w[6:0] == rvd_pkg::OPC_OP_IMM && (w[14:12] == 3'd1 || w[14:12] == 3'd5) &&
          $urandom_range(0, 3) != 0)
        w[31:26] = $urandom_range(0, 1) ? rvd_pkg::F6_ARITH : rvd_pkg::F6_LOGIC;
      if (w[6:0] == rvd_pkg::OPC_OP) begin
        case ($urandom_range(0, 3))
          0: w[31:25] = rvd_pkg::F7_BASE;
          1: w[31:25] = rvd_pkg::F7_MULDIV;
          2: w[31:25] = rvd_pkg::F7_ALT;
          default: ;
        endcase
      end
      if (w[6:0] == rvd_pkg::OPC_JALR && $urandom_range(0, 3) != 0) w[14:12] = 3'd0;
      if (w[6:0] == rvd_pkg::OPC_SYSTEM) begin
        case ($urandom_range(0, 3))
          0: w[31:7] = {11'd0, w[20], 13'd0};
          1: w[14:12] = 3'd0;
          default: ;
        endcase
      end
    end else if (pick < 90) begin
      w[1:0] = 2'b11;
    end
    return w;
  endfunction

  function automatic logic [2:0] random_avail();
    return ($urandom_range(0, 19) < 16) ? 3'd4 : 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [63:0] random_pc();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return {1'b0, {63{1'b1}}};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t: result %0d: %s", $time, beats_out, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic drive_insn(input logic [31:0] w, input logic [2:0] avail,
                            input logic [63:0] pc);
    int gap;
    gap = send_gaps_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(rvd_pkg::InDataBits - 99){1'b0}}, pc, avail, w};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_decodes.push_back(decode_insn(w, avail, pc));
    beats_in++;
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (pending_decodes.size() > 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
    // short and over-range byte counts
    drive_insn('1, 3'd0, '1);
    drive_insn(insn_fields(7'h7f, 5'd31, 5'd31, 3'd0, 5'd31, rvd_pkg::OPC_OP_IMM), 3'd3, '1);
    drive_insn(insn_fields(7'h7f, 5'd31, 5'd31, 3'd0, 5'd31, rvd_pkg::OPC_OP_IMM), 3'd7, '1);
    drive_insn(insn_fields(7'h3f, 5'd31, 5'd0, 3'd0, 5'd0, rvd_pkg::OPC_OP_IMM), 3'd5,
               64'd0);
    // compressed and unknown
    drive_insn(32'h0000_0000, 3'd4, 64'd0);
    drive_insn(32'hffff_fffe, 3'd4, '1);
    drive_insn('1, 3'd4, '1);
    // shift immediates, wide amounts and bad funct6, then op, load and store words
    drive_insn(insn_fields(7'h01, 5'd31, 5'd7, 3'd1, 5'd9, rvd_pkg::OPC_OP_IMM), 3'd4, 64'd4);
    drive_insn(insn_fields(7'h21, 5'd0, 5'd3, 3'd5, 5'd4, rvd_pkg::OPC_OP_IMM), 3'd4, 64'd8);
    drive_insn(insn_fields(7'h40, 5'd1, 5'd3, 3'd5, 5'd4, rvd_pkg::OPC_OP_IMM), 3'd4, 64'd8);
    drive_insn(insn_fields(rvd_pkg::F7_ALT, 5'd12, 5'd11, 3'd0, 5'd10, rvd_pkg::OPC_OP),
               3'd4, 64'd0);
    drive_insn(insn_fields(rvd_pkg::F7_MULDIV, 5'd31, 5'd31, 3'd7, 5'd31, rvd_pkg::OPC_OP),
               3'd4, 64'd0);
    drive_insn(insn_fields(rvd_pkg::F7_ALT, 5'd1, 5'd2, 3'd1, 5'd3, rvd_pkg::OPC_OP),
               3'd4, 64'd0);
    drive_insn(insn_fields(7'h40, 5'd0, 5'd2, 3'd3, 5'd8, rvd_pkg::OPC_LOAD), 3'd4, 64'd0);
    drive_insn(insn_fields(7'h7f, 5'd31, 5'd31, 3'd3, 5'd31, rvd_pkg::OPC_STORE), 3'd4,
               64'd0);
    // branch and jal targets wrapping both ways
    drive_insn(insn_fields(7'h7f, 5'd5, 5'd6, 3'd0, 5'h1f, rvd_pkg::OPC_BRANCH), 3'd4,
               64'd0);
    drive_insn(insn_fields(7'h3f, 5'd1, 5'd2, 3'd7, 5'h1f, rvd_pkg::OPC_BRANCH), 3'd4, '1);
    drive_insn(insn_fields(7'h00, 5'd1, 5'd2, 3'd2, 5'd0, rvd_pkg::OPC_BRANCH), 3'd4,
               64'd0);
    drive_insn(insn_fields(7'h7f, 5'd31, 5'd31, 3'd7, 5'd1, rvd_pkg::OPC_JAL), 3'd4, 64'd0);
    drive_insn(insn_fields(7'h3f, 5'd31, 5'd31, 3'd7, 5'd0, rvd_pkg::OPC_JAL), 3'd4, '1);
    drive_insn(insn_fields(7'h7f, 5'd31, 5'd31, 3'd7, 5'd31, rvd_pkg::OPC_LUI), 3'd4, 64'd0);
    // system: ecall, ebreak, ecall with rd set, csr forms, funct3 4
    drive_insn(insn_fields(7'h00, 5'd0, 5'd0, 3'd0, 5'd0, rvd_pkg::OPC_SYSTEM), 3'd4, 64'd0);
    drive_insn(insn_fields(7'h00, 5'd1, 5'd0, 3'd0, 5'd0, rvd_pkg::OPC_SYSTEM), 3'd4, 64'd0);
    drive_insn(insn_fields(7'h00, 5'd0, 5'd0, 3'd0, 5'd1, rvd_pkg::OPC_SYSTEM), 3'd4, 64'd0);
    drive_insn(insn_fields(7'h7f, 5'd31, 5'd31, 3'd1, 5'd31, rvd_pkg::OPC_SYSTEM), 3'd4,
               64'd0);
    drive_insn(insn_fields(7'h18, 5'd0, 5'd31, 3'd7, 5'd2, rvd_pkg::OPC_SYSTEM), 3'd4,
               64'd0);
    drive_insn(insn_fields(7'h00, 5'd0, 5'd0, 3'd4, 5'd0, rvd_pkg::OPC_SYSTEM), 3'd4, 64'd0);
    wait_for_drain();
  endtask

  task automatic test_output_stall();
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    hold_request = HoldCycles;
    repeat (40) drive_insn(random_insn(), random_avail(), random_pc());
    // sender pauses until every outstanding result is back
    wait_for_drain();
  endtask

  task automatic test_random_mix(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        send_gaps_on = (i == 0) ? 1'b0 : 1'($urandom_range(0, 1));
        recv_gaps_on = (i == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      end
      drive_insn(random_insn(), random_avail(), random_pc());
    end
    wait_for_drain();
  endtask

  // result checker
  always @(posedge clk_i) begin
    decode_t got;
    decode_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.is_bad = m_axis_tdata[0];
      got.len    = m_axis_tdata[3:1];
      got.mnem   = rvd_pkg::mnem_e'(m_axis_tdata[9:4]);
      got.form   = rvd_pkg::form_e'(m_axis_tdata[13:10]);
      got.rd     = m_axis_tdata[18:14];
      got.rs1    = m_axis_tdata[23:19];
      got.rs2    = m_axis_tdata[28:24];
      got.imm    = m_axis_tdata[61:29];
      got.csr    = m_axis_tdata[73:62];
      got.target = m_axis_tdata[137:74];
      if (pending_decodes.size() == 0) begin
        report_mismatch("result beat with no instruction outstanding");
      end else begin
        want = pending_decodes.pop_front();
        mnem_seen[want.mnem] = 1'b1;
        compare_field("is_bad", 64'(got.is_bad), 64'(want.is_bad));
        compare_field("insn_length", 64'(got.len), 64'(want.len));
        compare_field("mnemonic_index", 64'(got.mnem), 64'(want.mnem));
        compare_field("operand_form", 64'(got.form), 64'(want.form));
        compare_field("dest_reg", 64'(got.rd), 64'(want.rd));
        compare_field("src1_reg", 64'(got.rs1), 64'(want.rs1));
        compare_field("src2_reg", 64'(got.rs2), 64'(want.rs2));
        compare_field("immediate", 64'(got.imm), 64'(want.imm));
        compare_field("csr_number", 64'(got.csr), 64'(want.csr));
        compare_field("target_address", got.target, want.target);
      end
      beats_out++;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: %0d cycles without a beat, %0d results outstanding",
               idle_cycles, pending_decodes.size());
      $display("Verification failed");
      $finish;
    end
  end

  // result receiver with random and long hold-offs
  initial begin
    int gap;
    int k;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request > 0) begin
        m_axis_tready <= 1'b0;
        for (k = 0; k < hold_request; k++) @(posedge clk_i);
        hold_request = 0;
      end
      gap = recv_gaps_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int covered;
    rst_ni = 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    send_gaps_on = 1'b0;
    recv_gaps_on = 1'b0;
    hold_request = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_output_stall();
    test_random_mix(1280);
    repeat (8) @(posedge clk_i);
    covered = 0;
    foreach (mnem_seen[i]) covered += mnem_seen[i];
    $display("Summary: %0d instruction beats in, %0d results checked, %0d mismatches",
             beats_in, beats_out, mismatches);
    $display("Summary: %0d of 57 mnemonic codes seen, %0d cycles with input held off",
             covered, input_stall_cycles);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== rv64im_instruction_decoder.f =====
sv/rvd_pkg.sv
sv/rvd_classify.sv
sv/rvd_operands.sv
sv/rvd_target.sv
sv/rv64im_instruction_decoder.sv
tb/testbench.sv
